[rtl/point_in_planar_polygon_3d_defines.svh]
// assertion macros shared by the rtl
`ifndef POINT_IN_PLANAR_POLYGON_3D_DEFINES_SVH
`define POINT_IN_PLANAR_POLYGON_3D_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define PIP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pip assertion failed");

// condition must never be seen at a clock edge out of reset
`define PIP_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("pip forbidden condition seen");

`else

`define PIP_ASSERT(lbl, prop)
`define PIP_NEVER(lbl, expr)

`endif

`endif

[rtl/pip_pkg.sv]
package pip_pkg;

    // coordinate width of the request fields
    localparam int COORD_BITS       = 24;
    localparam int MAX_VERTICES_DEF = 256;

    localparam int NRM_W = 16;
    localparam int DIG_W = 16;

    // exact widths of the intermediate values
    localparam int DW = COORD_BITS + 2;       // midpoint direction
    localparam int EW = COORD_BITS + 1;       // vertex minus point
    localparam int UW = NRM_W + DW + 1;       // normal cross direction
    localparam int XW = EW + DW + 2;          // in-plane x
    localparam int YW = EW + UW + 2;          // in-plane y

    localparam int NDIG_N = (NRM_W + DIG_W - 1) / DIG_W;
    localparam int NDIG_E = (EW + DIG_W - 1) / DIG_W;
    localparam int NDIG_X = (XW + DIG_W - 1) / DIG_W;
    localparam int NDIG   = NDIG_X;
    localparam int NDW    = (NDIG > 1) ? $clog2(NDIG) : 1;

    localparam int AOPW = YW + 1;
    localparam int BOPW = NDIG * DIG_W;
    localparam int ACW  = AOPW + BOPW;

    localparam int VW = 3 * COORD_BITS;

    // action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NX = 2'd0;
    localparam logic [1:0] CFG_NY = 2'd1;
    localparam logic [1:0] CFG_NZ = 2'd2;

    localparam logic signed [NRM_W-1:0] NZ_RESET = 16'sd16384;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } t_req;

    typedef struct packed {
        logic       inside_res;
        logic [1:0] status;
        logic [8:0] vertex_count;
    } t_res;

    // multiply-accumulate micro operations
    typedef enum logic [3:0] {
        UOP_U0A, UOP_U0B, UOP_U1A, UOP_U1B, UOP_U2A, UOP_U2B,
        UOP_X0, UOP_X1, UOP_X2, UOP_Y0, UOP_Y1, UOP_Y2,
        UOP_C0, UOP_C1
    } t_uop;

    typedef struct packed {
        logic       ld_p;
        logic       wr;
        logic       clr_cnt;
        logic       ld_prev;
        logic       ld_d;
        logic       ld_e;
        logic       mac_go;
        logic       shift;
        logic       resp;
        logic       resp_inside;
        logic [1:0] resp_status;
        t_uop       uop;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic few;
        logic mid_nz;
        logic mac_busy;
        logic mac_done;
        logic acc_pos;
        logic acc_neg;
        logic y1_pos;
        logic y2_pos;
    } t_stat;

endpackage

[rtl/pip_ram.sv]
module pip_ram #(
    parameter int W     = 72,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pip_mac.sv]
`include "point_in_planar_polygon_3d_defines.svh"

// signed multiply-accumulate, one 16-bit digit of b per cycle
module pip_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic                              i_clr,
    input  logic signed [pip_pkg::AOPW-1:0]   i_a,
    input  logic [pip_pkg::BOPW-1:0]          i_b,
    input  logic [pip_pkg::NDW-1:0]           i_ndig,
    output logic                              o_busy,
    output logic                              o_done,
    output logic signed [pip_pkg::ACW-1:0]    o_acc
);

    localparam int PW = pip_pkg::AOPW + pip_pkg::DIG_W + 1;

    logic signed [pip_pkg::AOPW-1:0] r_a;
    logic [pip_pkg::BOPW-1:0]        r_b;
    logic [pip_pkg::NDW-1:0]         r_k;
    logic [pip_pkg::NDW-1:0]         r_last;
    logic                            r_busy;
    logic                            r_done;
    logic signed [pip_pkg::ACW-1:0]  r_acc;

    logic [pip_pkg::DIG_W-1:0]       w_dig16;
    logic signed [pip_pkg::DIG_W:0]  w_dig;
    logic signed [PW-1:0]            w_prod;
    logic signed [pip_pkg::ACW-1:0]  w_ext;
    logic signed [pip_pkg::ACW-1:0]  w_term;

    always_comb begin
        w_dig16 = r_b[pip_pkg::DIG_W*r_k +: pip_pkg::DIG_W];
        // top digit carries the sign
        if (r_k == r_last) begin
            w_dig = {w_dig16[pip_pkg::DIG_W-1], w_dig16};
        end else begin
            w_dig = {1'b0, w_dig16};
        end
        w_prod = r_a * w_dig;
        w_ext  = pip_pkg::ACW'(w_prod);
        w_term = w_ext <<< (pip_pkg::DIG_W * r_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
            r_last <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_last <= i_ndig;
            end else if (r_busy) begin
                if (r_k == r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a <= i_a;
            r_b <= i_b;
            if (i_clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_acc  = r_acc;

    `PIP_ASSERT(a_done_after_busy, r_done |-> $past(r_busy))
    `PIP_NEVER(a_go_while_busy, i_go && r_busy)

endmodule

[rtl/pip_dp.sv]
module pip_dp #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pip_pkg::t_req                        i_req,
    input  pip_pkg::t_cmd                        i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]      i_raddr,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [pip_pkg::NRM_W-1:0]            i_cfg_data,
    output pip_pkg::t_stat                       o_stat,
    output logic [$clog2(MAX_VERTICES+1)-1:0]    o_cnt,
    output logic                                 o_done,
    output pip_pkg::t_res                        o_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int C  = pip_pkg::COORD_BITS;

    logic signed [pip_pkg::NRM_W-1:0] r_nx, r_ny, r_nz;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic signed [C-1:0]              r_p    [3];
    logic signed [C-1:0]              r_prev [3];
    logic signed [pip_pkg::DW-1:0]    r_d    [3];
    logic signed [pip_pkg::UW-1:0]    r_u    [3];
    logic signed [pip_pkg::EW-1:0]    r_e    [3];
    logic signed [pip_pkg::XW-1:0]    r_x1, r_x2;
    logic signed [pip_pkg::YW-1:0]    r_y1, r_y2;
    logic                             r_done;
    pip_pkg::t_res                    r_res;

    logic [pip_pkg::VW-1:0]           w_rdata;
    logic signed [C-1:0]              w_rd   [3];
    logic signed [pip_pkg::DW-1:0]    w_dnx  [3];
    logic signed [pip_pkg::AOPW-1:0]  w_a;
    logic signed [pip_pkg::BOPW-1:0]  w_b;
    logic [pip_pkg::NDW-1:0]          w_ndig;
    logic                             w_clr;
    logic                             w_mbusy, w_mdone;
    logic signed [pip_pkg::ACW-1:0]   w_acc;

    pip_ram #(
        .W     (pip_pkg::VW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_req.coord_z, i_req.coord_y, i_req.coord_x}),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_rd[0] = w_rdata[C-1:0];
        w_rd[1] = w_rdata[2*C-1:C];
        w_rd[2] = w_rdata[3*C-1:2*C];
        for (int k = 0; k < 3; k++) begin
            w_dnx[k] = pip_pkg::DW'(r_prev[k]) + pip_pkg::DW'(w_rd[k])
                     - (pip_pkg::DW'(r_p[k]) <<< 1);
        end
    end

    // operand select for the multiply-accumulate unit
    always_comb begin
        w_a    = '0;
        w_b    = '0;
        w_clr  = 1'b0;
        w_ndig = pip_pkg::NDW'(pip_pkg::NDIG_N - 1);
        unique case (i_cmd.uop)
            pip_pkg::UOP_U0A: begin
                w_a = pip_pkg::AOPW'(r_d[2]); w_b = pip_pkg::BOPW'(r_ny); w_clr = 1'b1;
            end
            pip_pkg::UOP_U0B: begin
                w_a = -pip_pkg::AOPW'(r_d[1]); w_b = pip_pkg::BOPW'(r_nz);
            end
            pip_pkg::UOP_U1A: begin
                w_a = pip_pkg::AOPW'(r_d[0]); w_b = pip_pkg::BOPW'(r_nz); w_clr = 1'b1;
            end
            pip_pkg::UOP_U1B: begin
                w_a = -pip_pkg::AOPW'(r_d[2]); w_b = pip_pkg::BOPW'(r_nx);
            end
            pip_pkg::UOP_U2A: begin
                w_a = pip_pkg::AOPW'(r_d[1]); w_b = pip_pkg::BOPW'(r_nx); w_clr = 1'b1;
            end
            pip_pkg::UOP_U2B: begin
                w_a = -pip_pkg::AOPW'(r_d[0]); w_b = pip_pkg::BOPW'(r_ny);
            end
            pip_pkg::UOP_X0, pip_pkg::UOP_X1, pip_pkg::UOP_X2: begin
                w_ndig = pip_pkg::NDW'(pip_pkg::NDIG_E - 1);
                w_clr  = (i_cmd.uop == pip_pkg::UOP_X0);
                if (i_cmd.uop == pip_pkg::UOP_X0) begin
                    w_a = pip_pkg::AOPW'(r_d[0]); w_b = pip_pkg::BOPW'(r_e[0]);
                end else if (i_cmd.uop == pip_pkg::UOP_X1) begin
                    w_a = pip_pkg::AOPW'(r_d[1]); w_b = pip_pkg::BOPW'(r_e[1]);
                end else begin
                    w_a = pip_pkg::AOPW'(r_d[2]); w_b = pip_pkg::BOPW'(r_e[2]);
                end
            end
            pip_pkg::UOP_Y0, pip_pkg::UOP_Y1, pip_pkg::UOP_Y2: begin
                w_ndig = pip_pkg::NDW'(pip_pkg::NDIG_E - 1);
                w_clr  = (i_cmd.uop == pip_pkg::UOP_Y0);
                if (i_cmd.uop == pip_pkg::UOP_Y0) begin
                    w_a = pip_pkg::AOPW'(r_u[0]); w_b = pip_pkg::BOPW'(r_e[0]);
                end else if (i_cmd.uop == pip_pkg::UOP_Y1) begin
                    w_a = pip_pkg::AOPW'(r_u[1]); w_b = pip_pkg::BOPW'(r_e[1]);
                end else begin
                    w_a = pip_pkg::AOPW'(r_u[2]); w_b = pip_pkg::BOPW'(r_e[2]);
                end
            end
            pip_pkg::UOP_C0: begin
                w_ndig = pip_pkg::NDW'(pip_pkg::NDIG_X - 1);
                w_a = pip_pkg::AOPW'(r_y2); w_b = pip_pkg::BOPW'(r_x1); w_clr = 1'b1;
            end
            pip_pkg::UOP_C1: begin
                w_ndig = pip_pkg::NDW'(pip_pkg::NDIG_X - 1);
                w_a = -pip_pkg::AOPW'(r_y1); w_b = pip_pkg::BOPW'(r_x2);
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    pip_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mac_go),
        .i_clr   (w_clr),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_ndig  (w_ndig),
        .o_busy  (w_mbusy),
        .o_done  (w_mdone),
        .o_acc   (w_acc)
    );

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.clr_cnt) begin
            n_cnt = '0;
        end else if (i_cmd.wr) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_nx   <= '0;
            r_ny   <= '0;
            r_nz   <= pip_pkg::NZ_RESET;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= i_cmd.resp;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pip_pkg::CFG_NX: r_nx <= i_cfg_data;
                    pip_pkg::CFG_NY: r_ny <= i_cfg_data;
                    pip_pkg::CFG_NZ: r_nz <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_res.inside_res   <= i_cmd.resp_inside;
            r_res.status       <= i_cmd.resp_status;
            r_res.vertex_count <= 9'(n_cnt);
        end
        if (i_cmd.ld_p) begin
            r_p[0] <= i_req.coord_x;
            r_p[1] <= i_req.coord_y;
            r_p[2] <= i_req.coord_z;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.ld_prev) begin
                r_prev[k] <= w_rd[k];
            end
            if (i_cmd.ld_d) begin
                r_d[k] <= w_dnx[k];
            end
            if (i_cmd.ld_e) begin
                r_e[k] <= pip_pkg::EW'(w_rd[k]) - pip_pkg::EW'(r_p[k]);
            end
        end
        if (w_mdone) begin
            case (i_cmd.uop)
                pip_pkg::UOP_U0B: r_u[0] <= pip_pkg::UW'(w_acc);
                pip_pkg::UOP_U1B: r_u[1] <= pip_pkg::UW'(w_acc);
                pip_pkg::UOP_U2B: r_u[2] <= pip_pkg::UW'(w_acc);
                pip_pkg::UOP_X2:  r_x2   <= pip_pkg::XW'(w_acc);
                pip_pkg::UOP_Y2:  r_y2   <= pip_pkg::YW'(w_acc);
                default: ;
            endcase
        end
        if (i_cmd.shift) begin
            r_x1 <= r_x2;
            r_y1 <= r_y2;
        end
    end

    always_comb begin
        o_stat.full     = (r_cnt == CW'(MAX_VERTICES));
        o_stat.few      = (r_cnt < CW'(3));
        o_stat.mid_nz   = (w_dnx[0] != '0) || (w_dnx[1] != '0) || (w_dnx[2] != '0);
        o_stat.mac_busy = w_mbusy;
        o_stat.mac_done = w_mdone;
        o_stat.acc_pos  = !w_acc[pip_pkg::ACW-1] && (w_acc != '0);
        o_stat.acc_neg  = w_acc[pip_pkg::ACW-1];
        o_stat.y1_pos   = !r_y1[pip_pkg::YW-1] && (r_y1 != '0);
        o_stat.y2_pos   = !r_y2[pip_pkg::YW-1] && (r_y2 != '0);
    end

    assign o_cnt  = r_cnt;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/pip_ctrl.sv]
`include "point_in_planar_polygon_3d_defines.svh"

module pip_ctrl #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [1:0]                        i_action,
    input  pip_pkg::t_stat                    i_stat,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] i_cnt,
    output logic                              o_busy,
    output pip_pkg::t_cmd                     o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_raddr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MRD   = 10'b0000000010,
        S_MCHK  = 10'b0000000100,
        S_MGO   = 10'b0000001000,
        S_MWAIT = 10'b0000010000,
        S_ERD   = 10'b0000100000,
        S_ELAT  = 10'b0001000000,
        S_EVAL  = 10'b0010000000,
        S_CEVAL = 10'b0100000000,
        S_ADV   = 10'b1000000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_rdi, n_rdi;
    pip_pkg::t_uop r_uop, n_uop;
    logic          r_par, n_par;
    logic          w_last;

    assign w_last  = (r_rdi == i_cnt);
    assign o_raddr = w_last ? '0 : r_rdi[AW-1:0];
    assign o_busy  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_rdi   = r_rdi;
        n_uop   = r_uop;
        n_par   = r_par;
        o_cmd   = '0;
        o_cmd.uop = r_uop;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        pip_pkg::ACT_APPEND: begin
                            o_cmd.resp = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.resp_status = pip_pkg::ST_DROP;
                            end else begin
                                o_cmd.wr = 1'b1;
                            end
                        end
                        pip_pkg::ACT_CLEAR: begin
                            o_cmd.clr_cnt = 1'b1;
                            o_cmd.resp    = 1'b1;
                        end
                        pip_pkg::ACT_QUERY: begin
                            if (i_stat.few) begin
                                o_cmd.resp        = 1'b1;
                                o_cmd.resp_status = pip_pkg::ST_FEW;
                            end else begin
                                o_cmd.ld_p = 1'b1;
                                n_rdi      = '0;
                                n_par      = 1'b0;
                                n_state    = S_MRD;
                            end
                        end
                        default: begin
                            o_cmd.resp = 1'b1;
                        end
                    endcase
                end
            end
            S_MRD: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (r_rdi == '0) begin
                    o_cmd.ld_prev = 1'b1;
                    n_rdi   = r_rdi + 1'b1;
                    n_state = S_MRD;
                end else if (i_stat.mid_nz) begin
                    o_cmd.ld_d = 1'b1;
                    n_rdi   = '0;
                    n_uop   = pip_pkg::UOP_U0A;
                    n_state = S_MGO;
                end else if (w_last) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.ld_prev = 1'b1;
                    n_rdi   = r_rdi + 1'b1;
                    n_state = S_MRD;
                end
            end
            S_MGO: begin
                o_cmd.mac_go = 1'b1;
                n_state      = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.mac_done) begin
                    n_state = S_MGO;
                    unique case (r_uop)
                        pip_pkg::UOP_U0A: n_uop = pip_pkg::UOP_U0B;
                        pip_pkg::UOP_U0B: n_uop = pip_pkg::UOP_U1A;
                        pip_pkg::UOP_U1A: n_uop = pip_pkg::UOP_U1B;
                        pip_pkg::UOP_U1B: n_uop = pip_pkg::UOP_U2A;
                        pip_pkg::UOP_U2A: n_uop = pip_pkg::UOP_U2B;
                        pip_pkg::UOP_U2B: n_state = S_ERD;
                        pip_pkg::UOP_X0:  n_uop = pip_pkg::UOP_X1;
                        pip_pkg::UOP_X1:  n_uop = pip_pkg::UOP_X2;
                        pip_pkg::UOP_X2:  n_uop = pip_pkg::UOP_Y0;
                        pip_pkg::UOP_Y0:  n_uop = pip_pkg::UOP_Y1;
                        pip_pkg::UOP_Y1:  n_uop = pip_pkg::UOP_Y2;
                        pip_pkg::UOP_Y2:  n_state = S_EVAL;
                        pip_pkg::UOP_C0:  n_uop = pip_pkg::UOP_C1;
                        pip_pkg::UOP_C1:  n_state = S_CEVAL;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_ERD: begin
                n_state = S_ELAT;
            end
            S_ELAT: begin
                o_cmd.ld_e = 1'b1;
                n_uop      = pip_pkg::UOP_X0;
                n_state    = S_MGO;
            end
            S_EVAL: begin
                // first vertex only seeds the previous point
                if (r_rdi != '0 && (i_stat.y1_pos != i_stat.y2_pos)) begin
                    n_uop   = pip_pkg::UOP_C0;
                    n_state = S_MGO;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_CEVAL: begin
                if (i_stat.y2_pos ? i_stat.acc_pos : i_stat.acc_neg) begin
                    n_par = ~r_par;
                end
                n_state = S_ADV;
            end
            S_ADV: begin
                o_cmd.shift = 1'b1;
                if (w_last) begin
                    o_cmd.resp        = 1'b1;
                    o_cmd.resp_inside = r_par;
                    n_state           = S_IDLE;
                end else begin
                    n_rdi   = r_rdi + 1'b1;
                    n_state = S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdi   <= '0;
            r_uop   <= pip_pkg::UOP_U0A;
            r_par   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdi   <= n_rdi;
            r_uop   <= n_uop;
            r_par   <= n_par;
        end
    end

    `PIP_ASSERT(a_go_mac_free, o_cmd.mac_go |-> !i_stat.mac_busy)
    `PIP_ASSERT(a_rdi_bound, (r_state == S_MRD || r_state == S_ERD) |-> (r_rdi <= i_cnt))
    `PIP_ASSERT(a_walk_needs_three, (r_state == S_MRD) |-> !i_stat.few)

endmodule

[rtl/point_in_planar_polygon_3d.sv]
// point-in-polygon block for a planar polygon in 3d. vertices are appended one per
// request and a query point is tested with an even/odd crossing count. a request is
// taken when start is high and busy is low; each request gives exactly one result on
// o_res, marked by o_done for one cycle, and the receiver cannot stall it. append,
// clear and short queries answer on the next cycle and leave busy low, so one such
// request per cycle is possible. a query keeps busy high while it walks the edge
// midpoints up to the first one that differs from the point, then walks every edge,
// with an extra crossing step only for the edges that straddle the ray line; the
// result is marked on o_done in the cycle in which busy falls. the query time is set
// by the single shared multiply-accumulate unit (one 16-bit digit per cycle) and the
// one read port of the vertex memory. configuration writes go straight into the
// normal registers and must only be issued while busy is low.
module point_in_planar_polygon_3d #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request side
    input  logic                      start,
    output logic                      busy,
    input  pip_pkg::t_req             i_req,
    // result side
    output logic                      o_done,
    output pip_pkg::t_res             o_res,
    // plane normal registers
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [pip_pkg::NRM_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // command and status between sequencer and datapath
    pip_pkg::t_cmd  w_cmd;
    pip_pkg::t_stat w_stat;
    logic [CW-1:0]  w_cnt;
    logic [AW-1:0]  w_raddr;

    // sequencer: request decode, midpoint walk, edge walk, mac micro ops
    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_stat   (w_stat),
        .i_cnt    (w_cnt),
        .o_busy   (busy),
        .o_cmd    (w_cmd),
        .o_raddr  (w_raddr)
    );

    // datapath: vertex memory, exact wide arithmetic, result register
    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd      (w_cmd),
        .i_raddr    (w_raddr),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (w_stat),
        .o_cnt      (w_cnt),
        .o_done     (o_done),
        .o_res      (o_res)
    );

endmodule
